// File: rtl/ft12_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// FT1.2 frame receiver assertion macros
// Shared wrappers for the concurrent checks of the receiver, all clocked on
// clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FT12_FRAME_RECEIVER_ASSERT_SVH
`define FT12_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define FT12_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define FT12_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ft12_pkg.sv
// ----------------------------------------------------------------------------
// FT1.2 receiver package
// Types and constants shared by the parser, the result register and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package ft12_pkg;

	localparam logic [7:0] START_FIXED = 8'h10;
	localparam logic [7:0] START_VAR   = 8'h68;
	localparam logic [7:0] STOP_BYTE   = 8'h16;
	localparam logic [7:0] ACD_MASK    = 8'h20;
	localparam logic [7:0] DFC_MASK    = 8'h10;
	localparam logic [3:0] FC_SEND_CONFIRM = 4'd0;
	localparam logic [3:0] FC_USER_DATA    = 4'd8;

	localparam int unsigned TDATA_W = 40;

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_F_CTRL,
		PH_F_ADDR,
		PH_F_SUM,
		PH_F_END,
		PH_V_LEN1,
		PH_V_LEN2,
		PH_V_ST2,
		PH_V_DATA,
		PH_V_SUM,
		PH_V_END
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ADDRESS   = 3'd1,
		ST_END_BYTE  = 3'd2,
		ST_CHECKSUM  = 3'd3,
		ST_TRUNCATED = 3'd4,
		ST_NO_START  = 3'd5,
		ST_START2    = 3'd6
	} frame_status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} result_kind_t;

	typedef struct packed {
		result_kind_t  result_kind;
		logic [7:0]    data_byte;
		frame_status_t frame_status;
		logic          frame_kind;
		logic          access_demand;
		logic          flow_control;
		logic [3:0]    function_code;
		logic [7:0]    station_address;
		logic [7:0]    user_data_length;
		logic          deliver_user_data;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/ft12_frame_receiver.sv
// ----------------------------------------------------------------------------
// FT1.2 frame receiver
// Parses IEC 60870-5 FT1.2 fixed and variable link frames from a byte stream
// and reports user bytes and one status item per frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: rx_byte; tlast: chunk_end
//   m_axis    out        tdata: data_byte .. deliver_user_data; tuser: result_kind
//   apb       in/out     register 0 at address 0: expected_station_address
//
// An accepted item is held in the input stage register and parsed
// combinationally into the result register, so one item per cycle flows
// through while the sink keeps m_tready high. m_tvalid rises once the
// result register has been loaded. A waiting result stalls the parser, and
// the input stage then takes at most one more item before s_tready drops.
// arst_n clears all control state and the station address register.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_frame_receiver (
	input  wire         clk,
	input  wire         arst_n,
	// Input stream.
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire         s_tlast,   // chunk_end
	// Result stream.
	output logic        m_tvalid,
	input  wire         m_tready,
	// [7:0] data_byte, [10:8] frame_status, [11] frame_kind, [12] access_demand,
	// [13] flow_control, [17:14] function_code, [25:18] station_address,
	// [33:26] user_data_length, [34] deliver_user_data, [39:35] zero
	output logic [ft12_pkg::TDATA_W-1:0] m_tdata,
	output logic        m_tuser,   // [0] result_kind
	// Register port.
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "ft12_frame_receiver_assert.svh"

	// Station address register; only the word at address zero exists.
	logic [7:0] exp_addr_q;
	logic       reg_hit;

	assign reg_hit = (paddr[2] == 1'b0);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			exp_addr_q <= pwdata[7:0];
		end
	end

	assign prdata = reg_hit ? {24'd0, exp_addr_q} : 32'd0;

	// Input stage register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       out_valid;

	assign advance  = valid_s1 && (!out_valid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Parser: frame state advances once per item leaving the input stage.
	logic              p_valid;
	ft12_pkg::result_t p_res;
	ft12_pkg::result_t out_res;
	logic              deliver_good;

	ft12_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.rx_byte       (byte_s1),
		.chunk_end     (last_s1),
		.expected_addr (exp_addr_q),
		.res_valid     (p_valid),
		.res           (p_res)
	);

	ft12_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && p_valid),
		.load_res (p_res),
		.take     (m_tready),
		.valid    (out_valid),
		.res      (out_res)
	);

	assign m_tvalid = out_valid;
	assign m_tuser  = out_res.result_kind;
	assign m_tdata  = {5'd0, out_res.deliver_user_data, out_res.user_data_length,
		out_res.station_address, out_res.function_code, out_res.flow_control,
		out_res.access_demand, out_res.frame_kind, out_res.frame_status,
		out_res.data_byte};

	// A good variable frame status item, the only kind that may deliver.
	assign deliver_good = (out_res.result_kind == ft12_pkg::KIND_STATUS) &&
		(out_res.frame_status == ft12_pkg::ST_OK) && out_res.frame_kind;

	// A delivered frame is always a good variable frame.
	`FT12_ASSERT_NOW(a_deliver_ok, m_tvalid && m_tdata[34], deliver_good, "bad deliver flag")
	// A user data item carries nothing beside its byte.
	`FT12_ASSERT_NOW(a_data_clean, m_tvalid && !m_tuser, m_tdata[39:8] == 32'd0, "dirty data item")
	// The input side only stalls while an item sits in the input stage.
	`FT12_ASSERT_NOW(a_stall_cause, !s_tready, valid_s1 && out_valid && !m_tready, "bad stall")
	// A result waiting on the sink stays loaded through the next edge.
	`FT12_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid, "result dropped")

endmodule

`default_nettype wire

// File: rtl/ft12_parser.sv
// ----------------------------------------------------------------------------
// FT1.2 frame parser
// Holds the frame state and turns one byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_parser (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire  [7:0]            rx_byte,
	input  wire                   chunk_end,
	input  wire  [7:0]            expected_addr,
	output logic                  res_valid,
	output ft12_pkg::result_t     res
);

	ft12_pkg::phase_t phase_q, phase_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] ctrl_q, ctrl_d;
	logic [7:0] addr_q, addr_d;
	logic [7:0] chk_q, chk_d;
	logic       var_q, var_d;
	logic       done_q, done_d;
	logic       taken_q, taken_d;
	logic       st2bad_q, st2bad_d;

	always_comb begin
		logic                    ended;
		logic                    data_out;
		logic                    with_frame;
		ft12_pkg::frame_status_t status;
		logic [7:0]              pos_inc;

		phase_d  = phase_q;
		pos_d    = pos_q;
		len_d    = len_q;
		sum_d    = sum_q;
		ctrl_d   = ctrl_q;
		addr_d   = addr_q;
		chk_d    = chk_q;
		var_d    = var_q;
		done_d   = done_q;
		taken_d  = taken_q;
		st2bad_d = st2bad_q;
		ended      = 1'b0;
		data_out   = 1'b0;
		with_frame = 1'b1;
		status     = ft12_pkg::ST_OK;
		res_valid  = 1'b0;
		pos_inc    = pos_q + 8'd1;

		if (done_q) begin
			if (chunk_end) begin
				done_d = 1'b0;
			end
		end else if (phase_q == ft12_pkg::PH_HUNT) begin
			if (rx_byte == ft12_pkg::START_FIXED || rx_byte == ft12_pkg::START_VAR) begin
				pos_d    = '0;
				len_d    = '0;
				sum_d    = '0;
				ctrl_d   = '0;
				addr_d   = '0;
				chk_d    = '0;
				taken_d  = 1'b0;
				st2bad_d = 1'b0;
				var_d    = (rx_byte == ft12_pkg::START_VAR);
				phase_d  = var_d ? ft12_pkg::PH_V_LEN1 : ft12_pkg::PH_F_CTRL;
				if (chunk_end) begin
					phase_d   = ft12_pkg::PH_HUNT;
					status    = ft12_pkg::ST_TRUNCATED;
					res_valid = 1'b1;
				end
			end else if (chunk_end) begin
				status     = ft12_pkg::ST_NO_START;
				with_frame = 1'b0;
				res_valid  = 1'b1;
			end
		end else begin
			case (phase_q)
				ft12_pkg::PH_F_CTRL: begin
					ctrl_d  = rx_byte;
					sum_d   = rx_byte;
					phase_d = ft12_pkg::PH_F_ADDR;
				end
				ft12_pkg::PH_F_ADDR: begin
					addr_d  = rx_byte;
					taken_d = 1'b1;
					sum_d   = sum_q + rx_byte;
					phase_d = ft12_pkg::PH_F_SUM;
				end
				ft12_pkg::PH_F_SUM: begin
					chk_d   = rx_byte;
					phase_d = ft12_pkg::PH_F_END;
				end
				ft12_pkg::PH_F_END: begin
					ended = 1'b1;
					if (addr_q != expected_addr)
						status = ft12_pkg::ST_ADDRESS;
					else if (rx_byte != ft12_pkg::STOP_BYTE)
						status = ft12_pkg::ST_END_BYTE;
					else if (sum_q != chk_q)
						status = ft12_pkg::ST_CHECKSUM;
				end
				ft12_pkg::PH_V_LEN1: begin
					len_d   = rx_byte;
					phase_d = ft12_pkg::PH_V_LEN2;
				end
				ft12_pkg::PH_V_LEN2: begin
					phase_d = ft12_pkg::PH_V_ST2;
				end
				ft12_pkg::PH_V_ST2: begin
					st2bad_d = (rx_byte != ft12_pkg::START_VAR);
					pos_d    = '0;
					phase_d  = (len_q != 8'd0) ? ft12_pkg::PH_V_DATA : ft12_pkg::PH_V_SUM;
				end
				ft12_pkg::PH_V_DATA: begin
					if (pos_q == 8'd0) begin
						ctrl_d = rx_byte;
					end
					if (pos_q == 8'd1) begin
						addr_d  = rx_byte;
						taken_d = 1'b1;
					end
					sum_d    = sum_q + rx_byte;
					pos_d    = pos_inc;
					if (pos_inc == len_q) begin
						phase_d = ft12_pkg::PH_V_SUM;
					end
					data_out = 1'b1;
				end
				ft12_pkg::PH_V_SUM: begin
					chk_d   = rx_byte;
					phase_d = ft12_pkg::PH_V_END;
				end
				default: begin
					ended = 1'b1;
					if (addr_q != expected_addr)
						status = ft12_pkg::ST_ADDRESS;
					else if (st2bad_q)
						status = ft12_pkg::ST_START2;
					else if (rx_byte != ft12_pkg::STOP_BYTE)
						status = ft12_pkg::ST_END_BYTE;
					else if (sum_q != chk_q)
						status = ft12_pkg::ST_CHECKSUM;
				end
			endcase

			if (ended) begin
				phase_d   = ft12_pkg::PH_HUNT;
				done_d    = !chunk_end;
				res_valid = 1'b1;
			end else if (chunk_end) begin
				phase_d   = ft12_pkg::PH_HUNT;
				status    = (taken_d && addr_d != expected_addr) ?
					ft12_pkg::ST_ADDRESS : ft12_pkg::ST_TRUNCATED;
				res_valid = 1'b1;
			end else if (data_out) begin
				res_valid = 1'b1;
			end
		end

		res = '0;
		if (res_valid && !(data_out && !ended && !chunk_end)) begin
			res.result_kind  = ft12_pkg::KIND_STATUS;
			res.frame_status = status;
			if (with_frame) begin
				res.frame_kind       = var_d;
				res.access_demand    = |(ctrl_d & ft12_pkg::ACD_MASK);
				res.flow_control     = |(ctrl_d & ft12_pkg::DFC_MASK);
				res.function_code    = ctrl_d[3:0];
				res.station_address  = addr_d;
				res.user_data_length = var_d ? len_d : 8'd0;
				res.deliver_user_data = (status == ft12_pkg::ST_OK) && var_d &&
					(ctrl_d[3:0] == ft12_pkg::FC_SEND_CONFIRM ||
					 ctrl_d[3:0] == ft12_pkg::FC_USER_DATA);
			end
		end else if (res_valid) begin
			res.result_kind = ft12_pkg::KIND_DATA;
			res.data_byte   = rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ft12_pkg::PH_HUNT;
			pos_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			ctrl_q   <= '0;
			addr_q   <= '0;
			chk_q    <= '0;
			var_q    <= 1'b0;
			done_q   <= 1'b0;
			taken_q  <= 1'b0;
			st2bad_q <= 1'b0;
		end else if (en) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			len_q    <= len_d;
			sum_q    <= sum_d;
			ctrl_q   <= ctrl_d;
			addr_q   <= addr_d;
			chk_q    <= chk_d;
			var_q    <= var_d;
			done_q   <= done_d;
			taken_q  <= taken_d;
			st2bad_q <= st2bad_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ft12_out_reg.sv
// ----------------------------------------------------------------------------
// FT1.2 result register
// One-entry output register that holds a result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ft12_out_reg (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  ft12_pkg::result_t     load_res,
	input  wire                   take,
	output logic                  valid,
	output ft12_pkg::result_t     res
);

	logic              valid_q;
	ft12_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

	assign valid = valid_q;
	assign res   = res_q;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FT1.2 frame receiver testbench
// Sends fixed and variable link frames, broken frames and line noise in
// chunks. A local parser predicts every result item, and each result is
// compared with it field by field while both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb;

	import ft12_pkg::*;

	localparam logic [2:0] REG_STATION_ADDR = 3'd0;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned ITEMS_PER_SETTING = 225;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	ft12_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// Parser mirror: the phase and frame registers of the receiver, kept up to
	// date with every item that the block accepts.
	phase_t     rx_phase = PH_HUNT;
	logic [7:0] rx_pos = '0;
	logic [7:0] rx_len = '0;
	logic [7:0] rx_sum = '0;
	logic [7:0] rx_ctrl = '0;
	logic [7:0] rx_addr = '0;
	logic [7:0] rx_check = '0;
	logic       rx_var = 1'b0;
	logic       rx_skip = 1'b0;
	logic       rx_addr_taken = 1'b0;
	logic       rx_start2_bad = 1'b0;
	logic [7:0] station_addr = 8'h00;

	result_t    frame_results_due[$];
	logic [7:0] chunk_bytes[$];
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	bit         quiet_stream = 1'b0;

	// Builds the status item from whatever part of the frame has arrived.
	function automatic result_t status_item(frame_status_t st, bit with_frame);
		result_t r;
		r = '0;
		r.result_kind = KIND_STATUS;
		r.frame_status = st;
		if (with_frame) begin
			r.frame_kind = rx_var;
			r.access_demand = |(rx_ctrl & ACD_MASK);
			r.flow_control = |(rx_ctrl & DFC_MASK);
			r.function_code = rx_ctrl[3:0];
			r.station_address = rx_addr;
			r.user_data_length = rx_var ? rx_len : 8'd0;
			r.deliver_user_data = (st == ST_OK) && rx_var &&
				(rx_ctrl[3:0] == FC_SEND_CONFIRM || rx_ctrl[3:0] == FC_USER_DATA);
		end
		return r;
	endfunction

	// Predicts the result items caused by one accepted byte.
	task automatic ft12_parse(input logic [7:0] b, input logic ce);
		logic ended;
		logic data_out;
		frame_status_t st;
		result_t r;
		ended = 1'b0;
		data_out = 1'b0;
		st = ST_OK;
		// A finished frame leaves the rest of its chunk unread.
		if (rx_skip) begin
			if (ce)
				rx_skip = 1'b0;
			return;
		end
		if (rx_phase == PH_HUNT) begin
			if (b == START_FIXED || b == START_VAR) begin
				rx_pos = '0;
				rx_len = '0;
				rx_sum = '0;
				rx_ctrl = '0;
				rx_addr = '0;
				rx_check = '0;
				rx_addr_taken = 1'b0;
				rx_start2_bad = 1'b0;
				rx_var = (b == START_VAR);
				rx_phase = rx_var ? PH_V_LEN1 : PH_F_CTRL;
				if (ce) begin
					rx_phase = PH_HUNT;
					frame_results_due.push_back(status_item(ST_TRUNCATED, 1'b1));
				end
			end else if (ce) begin
				frame_results_due.push_back(status_item(ST_NO_START, 1'b0));
			end
			return;
		end
		case (rx_phase)
			PH_F_CTRL: begin
				rx_ctrl = b;
				rx_sum = b;
				rx_phase = PH_F_ADDR;
			end
			PH_F_ADDR: begin
				rx_addr = b;
				rx_addr_taken = 1'b1;
				rx_sum = rx_sum + b;
				rx_phase = PH_F_SUM;
			end
			PH_F_SUM: begin
				rx_check = b;
				rx_phase = PH_F_END;
			end
			PH_F_END: begin
				ended = 1'b1;
				if (rx_addr != station_addr)
					st = ST_ADDRESS;
				else if (b != STOP_BYTE)
					st = ST_END_BYTE;
				else if (rx_sum != rx_check)
					st = ST_CHECKSUM;
			end
			PH_V_LEN1: begin
				rx_len = b;
				rx_phase = PH_V_LEN2;
			end
			// The repeated length byte is taken without comparison.
			PH_V_LEN2: rx_phase = PH_V_ST2;
			PH_V_ST2: begin
				rx_start2_bad = (b != START_VAR);
				rx_pos = '0;
				rx_phase = (rx_len != 8'd0) ? PH_V_DATA : PH_V_SUM;
			end
			PH_V_DATA: begin
				if (rx_pos == 8'd0)
					rx_ctrl = b;
				if (rx_pos == 8'd1) begin
					rx_addr = b;
					rx_addr_taken = 1'b1;
				end
				rx_sum = rx_sum + b;
				rx_pos = rx_pos + 8'd1;
				if (rx_pos == rx_len)
					rx_phase = PH_V_SUM;
				data_out = 1'b1;
			end
			PH_V_SUM: begin
				rx_check = b;
				rx_phase = PH_V_END;
			end
			default: begin
				ended = 1'b1;
				if (rx_addr != station_addr)
					st = ST_ADDRESS;
				else if (rx_start2_bad)
					st = ST_START2;
				else if (b != STOP_BYTE)
					st = ST_END_BYTE;
				else if (rx_sum != rx_check)
					st = ST_CHECKSUM;
			end
		endcase
		if (ended) begin
			rx_phase = PH_HUNT;
			rx_skip = !ce;
			frame_results_due.push_back(status_item(st, 1'b1));
		end else if (ce) begin
			// The chunk ended inside the frame; a user byte on this item is
			// replaced by the status item.
			rx_phase = PH_HUNT;
			st = (rx_addr_taken && rx_addr != station_addr) ? ST_ADDRESS : ST_TRUNCATED;
			frame_results_due.push_back(status_item(st, 1'b1));
		end else if (data_out) begin
			r = '0;
			r.result_kind = KIND_DATA;
			r.data_byte = b;
			frame_results_due.push_back(r);
		end
	endtask

	function automatic string describe(result_t r);
		return $sformatf({"kind=%0d data=%02h status=%0d var=%0d acd=%0d dfc=%0d ",
			"fc=%0d addr=%02h len=%0d deliver=%0d"}, r.result_kind, r.data_byte,
			r.frame_status, r.frame_kind, r.access_demand, r.flow_control,
			r.function_code, r.station_address, r.user_data_length,
			r.deliver_user_data);
	endfunction

	// Gap before an item: mostly none, sometimes short, rarely long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_stream || r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Sends one byte and predicts its results once it has been accepted. The
	// valid stays high afterwards so that a following item can go out back to
	// back; wait_idle lowers it.
	task automatic send_item(input logic [7:0] b, input logic ce);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= ce;
		do @(posedge clk); while (!s_tready);
		ft12_parse(b, ce);
	endtask

	// Sends chunk_bytes as one chunk, chunk_end on its final byte.
	task automatic send_chunk();
		foreach (chunk_bytes[i])
			send_item(chunk_bytes[i], i == chunk_bytes.size() - 1);
	endtask

	// Stops the input stream and waits until every predicted item is out and
	// the pipeline has had time to settle.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (frame_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the station address, then reads it back.
	task automatic set_station_address(input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_STATION_ADDR;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		station_addr = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'd0, value}) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("station address read back %h, expected %h", prdata, value);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == START_FIXED || b == START_VAR);
		return b;
	endfunction

	// Draws one chunk: mostly a well-formed frame with random content, with
	// some frames damaged, cut short or followed by bytes that are skipped,
	// and now and then plain line noise.
	task automatic build_chunk();
		logic [7:0] ctrl;
		logic [7:0] addr;
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] d;
		int unsigned pick;
		int unsigned n;
		int unsigned cut;
		chunk_bytes.delete();
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			n = $urandom_range(1, 6);
			repeat (n) chunk_bytes.push_back(8'($urandom));
			return;
		end
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) chunk_bytes.push_back(filler_byte());
		ctrl = 8'($urandom);
		if ($urandom_range(0, 2) == 0)
			ctrl[3:0] = $urandom_range(0, 1) ? FC_USER_DATA : FC_SEND_CONFIRM;
		addr = ($urandom_range(0, 5) == 0) ? 8'($urandom) : station_addr;
		if (pick < 45) begin
			sum = ctrl + addr;
			chunk_bytes.push_back(START_FIXED);
			chunk_bytes.push_back(ctrl);
			chunk_bytes.push_back(addr);
		end else begin
			len = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
			sum = '0;
			chunk_bytes.push_back(START_VAR);
			chunk_bytes.push_back(len);
			chunk_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : len);
			chunk_bytes.push_back(($urandom_range(0, 9) == 0) ? filler_byte() : START_VAR);
			for (int i = 0; i < len; i++) begin
				d = (i == 0) ? ctrl : (i == 1) ? addr : 8'($urandom);
				chunk_bytes.push_back(d);
				sum = sum + d;
			end
		end
		if ($urandom_range(0, 7) == 0)
			sum = sum + 8'($urandom_range(1, 255));
		chunk_bytes.push_back(sum);
		chunk_bytes.push_back(($urandom_range(0, 7) == 0) ?
			8'(STOP_BYTE + 8'($urandom_range(1, 255))) : STOP_BYTE);
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			cut = $urandom_range(0, chunk_bytes.size() - 2);
			while (chunk_bytes.size() > cut + 1)
				void'(chunk_bytes.pop_back());
		end else if (pick < 30) begin
			n = $urandom_range(1, 4);
			repeat (n) chunk_bytes.push_back(8'($urandom));
		end
	endtask

	// Special cases with the address register at its reset value of zero.
	task automatic test_special_cases();
		// A chunk with no start byte.
		chunk_bytes = '{8'hFF};
		send_chunk();
		// A chunk that ends on the start byte itself.
		chunk_bytes = '{START_FIXED};
		send_chunk();
		// Fixed frame with both ACD and DFC set.
		chunk_bytes = '{START_FIXED, 8'h3F, 8'h00, 8'h3F, STOP_BYTE};
		send_chunk();
		// Variable frame without user bytes, repeated length different: the
		// missing address reads as zero and matches.
		chunk_bytes = '{START_VAR, 8'h00, 8'h05, START_VAR, 8'h00, STOP_BYTE};
		send_chunk();
		// User data frame followed by a byte that is skipped.
		chunk_bytes = '{START_VAR, 8'h02, 8'h02, START_VAR, 8'h08, 8'h00, 8'h08,
			STOP_BYTE, 8'h00};
		send_chunk();
		// Chunk ends right after a foreign address.
		chunk_bytes = '{START_FIXED, 8'h00, 8'h12};
		send_chunk();
		wait_idle();
	endtask

	// The top address value, written and read back, with a frame that matches.
	task automatic test_address_register();
		set_station_address(8'hFF);
		chunk_bytes = '{START_FIXED, 8'h00, 8'hFF, 8'hFF, STOP_BYTE};
		send_chunk();
		wait_idle();
	endtask

	// Random chunks under several station addresses, both extremes included.
	task automatic test_random_traffic();
		logic [7:0] settings[4];
		int unsigned sent;
		settings[0] = 8'h00;
		settings[1] = 8'hFF;
		settings[2] = 8'($urandom);
		settings[3] = 8'($urandom);
		foreach (settings[k]) begin
			set_station_address(settings[k]);
			sent = 0;
			while (sent < ITEMS_PER_SETTING) begin
				build_chunk();
				quiet_stream = ($urandom_range(0, 4) == 0);
				send_chunk();
				sent += chunk_bytes.size();
			end
			quiet_stream = 1'b0;
			wait_idle();
		end
	endtask

	// Result sink: random stalls, mostly short, a few long, and runs with no
	// stall at all.
	int unsigned sink_hold = 0;
	int unsigned sink_run = 0;
	always @(negedge clk) begin : sink_ctrl
		int unsigned r;
		logic take;
		take = 1'b1;
		if (sink_hold != 0) begin
			sink_hold--;
			take = 1'b0;
		end else if (sink_run != 0) begin
			sink_run--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				sink_run = $urandom_range(20, 80);
			end else if (r < 25) begin
				sink_hold = (r < 22) ? $urandom_range(0, 2) : $urandom_range(4, 30);
				take = 1'b0;
			end
		end
		m_tready <= take;
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.result_kind = result_kind_t'(m_tuser);
			got.data_byte = m_tdata[7:0];
			got.frame_status = frame_status_t'(m_tdata[10:8]);
			got.frame_kind = m_tdata[11];
			got.access_demand = m_tdata[12];
			got.flow_control = m_tdata[13];
			got.function_code = m_tdata[17:14];
			got.station_address = m_tdata[25:18];
			got.user_data_length = m_tdata[33:26];
			got.deliver_user_data = m_tdata[34];
			if (frame_results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("result with nothing pending: %s", describe(got));
			end else begin
				want = frame_results_due.pop_front();
				if (got !== want || m_tdata[39:35] !== 5'd0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("result mismatch\n  expected %s\n  actual   %s pad=%h",
							describe(want), describe(got), m_tdata[39:35]);
				end
			end
		end
	end

	// Ends the run when neither stream nor the register port moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_special_cases();
		test_address_register();
		test_random_traffic();
		wait_idle();
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ft12_pkg.sv
rtl/ft12_parser.sv
rtl/ft12_out_reg.sv
rtl/ft12_frame_receiver.sv
sim/tb.sv
